@@ hdl/otl_pkg.sv @@
// Shared types and constants for the overcurrent trip latch.
// No dependencies; imported by every module in hdl/.
package otl_pkg;

    localparam int CurrentW = 16;
    localparam int CountW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int InDataW  = 24;  // 17 field bits padded to bytes
    localparam int OutDataW = 8;   // 2 field bits padded to a byte

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_OVER_LIMIT    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TRIP_COUNT    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RELEASE_COUNT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_STRIKE_LIMIT  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 3'd4;

    // Reset values
    localparam logic [CurrentW-1:0] RST_OVER_LIMIT    = 16'd38000;
    localparam logic [CountW-1:0]   RST_TRIP_COUNT    = 8'd3;
    localparam logic [CountW-1:0]   RST_RELEASE_COUNT = 8'd15;
    localparam logic [CountW-1:0]   RST_STRIKE_LIMIT  = 8'd3;
    localparam logic [CountW-1:0]   RST_TIMEOUT_TICKS = 8'd240;

    typedef struct packed {
        logic [CurrentW-1:0] over_limit;
        logic [CountW-1:0]   trip_count;
        logic [CountW-1:0]   release_count;
        logic [CountW-1:0]   strike_limit;
        logic [CountW-1:0]   timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic trip;
        logic stop_request;
    } t_result;

endpackage

@@ hdl/otl_cfg_regs.sv @@
// Configuration register file for the overcurrent trip latch.
// Depends on otl_pkg.
module otl_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [otl_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [otl_pkg::CfgDataW-1:0] i_cfg_data,
    output otl_pkg::t_cfg                o_cfg
);
    import otl_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_limit    <= RST_OVER_LIMIT;
            r_cfg.trip_count    <= RST_TRIP_COUNT;
            r_cfg.release_count <= RST_RELEASE_COUNT;
            r_cfg.strike_limit  <= RST_STRIKE_LIMIT;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OVER_LIMIT:    r_cfg.over_limit    <= i_cfg_data;
                REG_TRIP_COUNT:    r_cfg.trip_count    <= i_cfg_data[CountW-1:0];
                REG_RELEASE_COUNT: r_cfg.release_count <= i_cfg_data[CountW-1:0];
                REG_STRIKE_LIMIT:  r_cfg.strike_limit  <= i_cfg_data[CountW-1:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[CountW-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

endmodule

@@ hdl/otl_trip_core.sv @@
// Trip/strike/stop state and its one-tick next-state logic.
// Depends on otl_pkg.
module otl_trip_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  otl_pkg::t_cfg                i_cfg,
    input  logic                         i_step,
    input  logic [otl_pkg::CurrentW-1:0] i_current,
    input  logic                         i_override,
    output otl_pkg::t_result             o_result
);
    import otl_pkg::*;

    logic              r_trip_flag, n_trip_flag;
    logic [CountW-1:0] r_over_ticks, n_over_ticks;
    logic [CountW-1:0] r_low_ticks, n_low_ticks;
    logic [CountW-1:0] r_strikes, n_strikes;
    logic [CountW-1:0] r_timeout, n_timeout;
    logic              stop;

    logic [CountW-1:0] over_inc, low_inc, tmo_inc, strike_window;

    assign over_inc      = r_over_ticks + 8'd1;
    assign low_inc       = r_low_ticks + 8'd1;
    assign tmo_inc       = r_timeout + 8'd1;
    assign strike_window = i_cfg.strike_limit - 8'd1;

    always_comb begin
        n_trip_flag  = r_trip_flag;
        n_over_ticks = r_over_ticks;
        n_low_ticks  = r_low_ticks;
        n_strikes    = r_strikes;
        n_timeout    = r_timeout;
        stop         = 1'b0;
        if (i_current >= i_cfg.over_limit) begin
            // high tick
            n_low_ticks = '0;
            if (over_inc >= i_cfg.trip_count) begin
                n_strikes    = r_strikes + 8'd1;
                n_over_ticks = '0;
                n_trip_flag  = 1'b1;
            end else begin
                n_over_ticks = over_inc;
            end
        end else if (r_strikes < i_cfg.strike_limit) begin
            // low tick below the latch; forgive strikes in the last window
            if (r_strikes == strike_window) begin
                if (tmo_inc >= i_cfg.timeout_ticks) begin
                    n_strikes = '0;
                    n_timeout = '0;
                end else begin
                    n_timeout = tmo_inc;
                end
            end
            n_over_ticks = '0;
            if (low_inc > i_cfg.release_count) begin
                n_low_ticks = '0;
                n_trip_flag = 1'b0;
            end else begin
                n_low_ticks = low_inc;
            end
        end else begin
            // latched stop; timeout count keeps its value on release
            n_timeout = tmo_inc;
            stop      = 1'b1;
            if (i_override || (tmo_inc >= i_cfg.timeout_ticks)) begin
                n_strikes   = '0;
                n_trip_flag = 1'b0;
                stop        = 1'b0;
            end
        end
    end

    assign o_result.trip         = n_trip_flag;
    assign o_result.stop_request = stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip_flag  <= 1'b0;
            r_over_ticks <= '0;
            r_low_ticks  <= '0;
            r_strikes    <= '0;
            r_timeout    <= '0;
        end else if (i_step) begin
            r_trip_flag  <= n_trip_flag;
            r_over_ticks <= n_over_ticks;
            r_low_ticks  <= n_low_ticks;
            r_strikes    <= n_strikes;
            r_timeout    <= n_timeout;
        end
    end

endmodule

@@ hdl/overcurrent_trip_latch.sv @@
// Top level of the overcurrent trip latch: stream ports, input and result registers.
// Depends on otl_pkg, otl_cfg_regs and otl_trip_core.
//
// One request per current sample, one result per request, in order. A sample
// is captured in an input register, run through the counter update when the
// result register can take it, and written to the result register.
// Throughput is one sample per clock:
// both register stages advance together whenever the result register is
// empty or being drained, so the only limit is the downstream tready.
// Configuration writes are accepted every cycle and should only be made
// while no sample is in flight.
module overcurrent_trip_latch (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [otl_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [otl_pkg::CfgDataW-1:0] i_cfg_data,
    // sample stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] drive_current, [16] stop_override, [23:17] zero
    input  logic [otl_pkg::InDataW-1:0]  s_axis_tdata,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] trip, [1] stop_request, [7:2] zero
    output logic [otl_pkg::OutDataW-1:0] m_axis_tdata
);
    import otl_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    // input stage
    logic                r_in_valid;
    logic [CurrentW-1:0] r_in_current;
    logic                r_in_override;

    // result stage
    logic    r_out_valid;
    t_result r_out;

    logic out_ready;   // result register can take a new value
    logic step;        // input stage moves into the core this cycle

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    otl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    otl_trip_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_step     (step),
        .i_current  (r_in_current),
        .i_override (r_in_override),
        .o_result   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_current  <= s_axis_tdata[CurrentW-1:0];
            r_in_override <= s_axis_tdata[CurrentW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, r_out.stop_request, r_out.trip};

endmodule

@@ tb/otl_trip_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the overcurrent trip latch: watches the config, sample and
// result channels, predicts trip/stop per sample and compares. Depends on otl_pkg.
module otl_trip_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [otl_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [otl_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [otl_pkg::InDataW-1:0]  s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [otl_pkg::OutDataW-1:0] m_axis_tdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import otl_pkg::*;

    // mirrored register file
    logic [CurrentW-1:0] lim_current;
    logic [CountW-1:0]   lim_trip;
    logic [CountW-1:0]   lim_release;
    logic [CountW-1:0]   lim_strikes;
    logic [CountW-1:0]   lim_timeout;

    // mirrored protection state
    logic                tripped;
    logic [CountW-1:0]   high_run;
    logic [CountW-1:0]   low_run;
    logic [CountW-1:0]   strike_cnt;
    logic [CountW-1:0]   timeout_cnt;

    t_result predicted_flags[$];
    int      mismatches;

    // One tick of the trip/stop logic; updates the mirrored state.
    function automatic t_result advance_trip_state(logic [CurrentW-1:0] cur, logic ovr);
        t_result         res;
        logic            stop;
        logic [CountW-1:0] window;
        stop   = 1'b0;
        window = lim_strikes - 8'd1;
        if (cur >= lim_current) begin
            high_run = high_run + 8'd1;
            low_run  = '0;
            if (high_run >= lim_trip) begin
                strike_cnt = strike_cnt + 8'd1;
                high_run   = '0;
                tripped    = 1'b1;
            end
        end else if (strike_cnt < lim_strikes) begin
            // one strike short of the limit: low ticks run the forgiveness timer
            if (strike_cnt == window) begin
                timeout_cnt = timeout_cnt + 8'd1;
                if (timeout_cnt >= lim_timeout) begin
                    strike_cnt  = '0;
                    timeout_cnt = '0;
                end
            end
            low_run  = low_run + 8'd1;
            high_run = '0;
            if (low_run > lim_release) begin
                low_run = '0;
                tripped = 1'b0;
            end
        end else begin
            // latched stop; override or timeout drops it, timer keeps its value
            timeout_cnt = timeout_cnt + 8'd1;
            stop        = 1'b1;
            if (ovr || timeout_cnt >= lim_timeout) begin
                strike_cnt = '0;
                tripped    = 1'b0;
                stop       = 1'b0;
            end
        end
        res.trip         = tripped;
        res.stop_request = stop;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            lim_current = RST_OVER_LIMIT;
            lim_trip    = RST_TRIP_COUNT;
            lim_release = RST_RELEASE_COUNT;
            lim_strikes = RST_STRIKE_LIMIT;
            lim_timeout = RST_TIMEOUT_TICKS;
            tripped     = 1'b0;
            high_run    = '0;
            low_run     = '0;
            strike_cnt  = '0;
            timeout_cnt = '0;
            mismatches  = 0;
            predicted_flags.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OVER_LIMIT:    lim_current = i_cfg_data[CurrentW-1:0];
                    REG_TRIP_COUNT:    lim_trip    = i_cfg_data[CountW-1:0];
                    REG_RELEASE_COUNT: lim_release = i_cfg_data[CountW-1:0];
                    REG_STRIKE_LIMIT:  lim_strikes = i_cfg_data[CountW-1:0];
                    REG_TIMEOUT_TICKS: lim_timeout = i_cfg_data[CountW-1:0];
                    default: ;
                endcase
            end
            // compare before pushing so a stray result never meets this cycle's request
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_flags.size() == 0) begin
                    $display("%0t: unexpected result trip=%0b stop=%0b", $time,
                             m_axis_tdata[0], m_axis_tdata[1]);
                    mismatches++;
                end else begin
                    want = predicted_flags.pop_front();
                    if (m_axis_tdata[0] !== want.trip) begin
                        $display("%0t: trip expected %0b actual %0b", $time,
                                 want.trip, m_axis_tdata[0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[1] !== want.stop_request) begin
                        $display("%0t: stop_request expected %0b actual %0b", $time,
                                 want.stop_request, m_axis_tdata[1]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_flags.push_back(advance_trip_state(s_axis_tdata[CurrentW-1:0],
                                                             s_axis_tdata[CurrentW]));
        end
        o_pending    <= predicted_flags.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the overcurrent trip latch: clock, reset, config writes and
// sample/result traffic. Depends on otl_pkg, overcurrent_trip_latch, otl_trip_checker.
module tb;
    import otl_pkg::*;

    localparam int HOLD_CYCLES = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;

    int fail_count;
    int pending;

    // idling knobs, percent of cycles
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_req;
    bit hold_done;
    int hold_left;

    // current settings, kept to shape the samples
    int set_limit;
    int set_trip;
    int set_release;
    int set_timeout;

    overcurrent_trip_latch i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    otl_trip_checker trip_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off once requested
    initial begin
        m_axis_tready <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    // valid stays up; the caller drops it after the last write
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // all five registers; only called with nothing in flight
    task automatic apply_settings(input int limit, input int trip, input int rel,
                                  input int strike, input int tmo);
        set_limit   = limit;
        set_trip    = trip;
        set_release = rel;
        set_timeout = tmo;
        write_reg(REG_OVER_LIMIT, limit[15:0]);
        write_reg(REG_TRIP_COUNT, {8'd0, trip[7:0]});
        write_reg(REG_RELEASE_COUNT, {8'd0, rel[7:0]});
        write_reg(REG_STRIKE_LIMIT, {8'd0, strike[7:0]});
        write_reg(REG_TIMEOUT_TICKS, {8'd0, tmo[7:0]});
        i_cfg_valid <= 1'b0;
    endtask

    // one sample request; sender gaps come first, tvalid stays up until taken
    task automatic send_sample(input logic [CurrentW-1:0] cur, input logic ovr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ovr, cur};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // sender pause until the checker holds no open prediction
    task automatic drain();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Runs of high and low ticks sized to the current counts, so trips,
    // strikes, releases, timeouts and latched stops all get exercised;
    // about one sample in ten is plain noise over the full range.
    task automatic random_samples(input int count);
        int          run_left;
        bit          run_high;
        int          span;
        int          cur;
        logic        ovr;
        run_left = 0;
        run_high = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_high = ($urandom_range(0, 1) == 1);
                if (run_high)
                    run_left = $urandom_range(1, (set_trip == 0) ? 2 : set_trip + 1);
                else if ($urandom_range(0, 3) == 0)
                    run_left = $urandom_range(1, ((set_release > set_timeout) ?
                                                  set_release : set_timeout) + 2);
                else
                    run_left = $urandom_range(1, 4);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                cur = $urandom_range(0, 65535);
            end else if (run_high || set_limit == 0) begin
                span = 65535 - set_limit;
                if ($urandom_range(0, 1))
                    cur = $urandom_range(65535, set_limit);
                else
                    cur = set_limit + $urandom_range(0, (span < 8) ? span : 8);
            end else begin
                span = set_limit - 1;
                if ($urandom_range(0, 1))
                    cur = $urandom_range(span, 0);
                else
                    cur = span - $urandom_range(0, (span < 8) ? span : 8);
            end
            ovr = ($urandom_range(0, 15) == 0);
            send_sample(cur[15:0], ovr);
        end
        end_burst();
    endtask

    initial begin
        hold_req = 1'b0;
        set_idling(0, 0);
        set_limit   = RST_OVER_LIMIT;
        set_trip    = RST_TRIP_COUNT;
        set_release = RST_RELEASE_COUNT;
        set_timeout = RST_TIMEOUT_TICKS;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_OVER_LIMIT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: just below and at the limit, three highs give a strike
        send_sample(16'd37999, 1'b0);
        send_sample(16'd38000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd38000, 1'b0);
        end_burst();
        drain();

        // tight settings so strikes, forgiveness and the latch show up quickly
        apply_settings(1000, 1, 0, 2, 3);
        send_sample(16'd0, 1'b0);       // window: timer runs
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b1);       // timer expires, strikes forgiven
        send_sample(16'd1000, 1'b0);    // exactly at the limit
        send_sample(16'd999, 1'b0);
        send_sample(16'hFFFF, 1'b1);    // override on a high tick does nothing
        send_sample(16'd5, 1'b0);       // latched stop
        send_sample(16'd0, 1'b1);       // override releases the latch
        send_sample(16'd1000, 1'b0);
        send_sample(16'd1001, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd6, 1'b0);
        send_sample(16'd7, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'd998, 1'b0);
        end_burst();
        drain();

        // back to the reset values, no idling
        apply_settings(38000, 3, 15, 3, 240);
        random_samples(150);
        drain();

        set_idling(48, 0);
        apply_settings(500, 1, 3, 2, 5);
        random_samples(200);
        drain();

        // zero strike limit: every low tick takes the latched branch;
        // release count at its maximum, though no low tick reaches the release counter
        set_idling(0, 48);
        apply_settings(65535, 2, 255, 0, 7);
        random_samples(150);
        drain();

        // every tick high, zero trip count: each tick is a strike, strikes wrap
        set_idling(34, 34);
        apply_settings(0, 0, 0, 1, 1);
        random_samples(300);
        drain();

        apply_settings(20000, 255, 254, 255, 255);
        random_samples(150);
        drain();

        // pressure: long result hold-off while samples keep coming, then a full pause
        set_idling(0, 0);
        apply_settings(38000, 3, 15, 3, 240);
        random_samples(60);
        hold_req = 1'b1;
        random_samples(60);
        drain();
        random_samples(80);
        drain();

        set_idling(48, 48);
        apply_settings(1234, 4, 6, 3, 20);
        random_samples(200);
        drain();

        repeat (10) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d predicted results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
